@@ src/frame_interval_averager_top_macros.svh @@
// Assertion macros used by the frame interval averager RTL.
`ifndef FRAME_INTERVAL_AVERAGER_TOP_MACROS_SVH
`define FRAME_INTERVAL_AVERAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame interval averager assertion failed");

// Next-cycle implication, disabled during reset.
`define FIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame interval averager assertion failed");

`endif

@@ src/fia_pkg.sv @@
// Package with shared types and constants of the frame interval averager.
package fia_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam logic [31:0] TPS_RESET = 32'd10000000;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_REBASE = 1'b1;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_TPS = '0;

  typedef struct packed {
    logic        command;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_ticks;
    logic [31:0] average_ticks;
    logic [31:0] frame_rate;
    logic [6:0]  samples_held;
  } out_item_t;

endpackage

@@ src/fia_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/fia_divider.sv @@
// Restoring unsigned divider that retires one quotient bit per cycle.
module fia_divider #(
  parameter int DIVIDEND_W = 38,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  assign trial     = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIVIDEND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/fia_ctrl.sv @@
// Sequencer, statistics registers and result register of the frame interval averager.
`include "frame_interval_averager_top_macros.svh"

module fia_ctrl import fia_pkg::*; #(
  parameter int DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] tps,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = 32 + $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GATE = 3'd1;
  localparam logic [2:0] S_DROP = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [63:0]      last_stamp_r, last_stamp_nxt;
  logic [31:0]      ticks_r, ticks_nxt;
  logic             accept_r, accept_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      mean_r, mean_nxt;
  logic [31:0]      frames_r, frames_nxt;
  logic [32:0]      acc_r, acc_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             in_accept;
  logic [63:0]      diff;
  logic [31:0]      sat_ticks;
  logic [31:0]      gap;
  logic [32:0]      acc_sum;
  logic [31:0]      frames_inc;
  logic             full;
  logic             out_free;
  logic             ram_we;
  logic             ram_re;
  logic [31:0]      ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  assign in_accept  = in_valid && (state_r == S_IDLE);
  assign in_stall   = state_r != S_IDLE;
  assign diff       = in_item.timestamp - last_stamp_r;
  assign sat_ticks  = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
  assign gap        = (ticks_r >= mean_r) ? (ticks_r - mean_r) : (mean_r - ticks_r);
  assign acc_sum    = acc_r + {1'b0, ticks_r};
  assign frames_inc = frames_r + 32'd1;
  assign full       = count_r == DEPTH_C;
  assign out_free   = !out_valid_r || !out_stall;

  fia_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ticks_r),
    .re    (ram_re),
    .raddr (wr_ptr_r),
    .rdata (ram_rdata)
  );

  fia_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt      = state_r;
    last_stamp_nxt = last_stamp_r;
    ticks_nxt      = ticks_r;
    accept_nxt     = accept_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    mean_nxt       = mean_r;
    frames_nxt     = frames_r;
    acc_nxt        = acc_r;
    rate_nxt       = rate_r;
    wr_ptr_nxt     = wr_ptr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    div_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          last_stamp_nxt = in_item.timestamp;
          ram_re         = 1'b1;
          if (in_item.command == CMD_REBASE) begin
            ticks_nxt = 32'd0;
            state_nxt = S_EMIT;
          end else begin
            ticks_nxt = sat_ticks;
            state_nxt = S_GATE;
          end
        end
      end
      S_GATE: begin
        accept_nxt = gap < tps;
        if (acc_sum > {1'b0, tps}) begin
          rate_nxt   = frames_inc;
          frames_nxt = 32'd0;
          acc_nxt    = 33'd0;
        end else begin
          frames_nxt = frames_inc;
          acc_nxt    = acc_sum;
        end
        state_nxt = S_DROP;
      end
      S_DROP: begin
        if (accept_r && full) begin
          sum_nxt = sum_r - SUM_W'(ram_rdata);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (accept_r) begin
          sum_nxt    = sum_r + SUM_W'(ticks_r);
          ram_we     = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
          if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (count_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          mean_nxt  = 32'd0;
          state_nxt = S_EMIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          mean_nxt  = div_quotient[31:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.frame_ticks   = ticks_r;
          out_item_nxt.average_ticks = mean_r;
          out_item_nxt.frame_rate    = rate_r;
          out_item_nxt.samples_held  = 7'(count_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_stamp_r <= '0;
      sum_r        <= '0;
      count_r      <= '0;
      mean_r       <= '0;
      frames_r     <= '0;
      acc_r        <= '0;
      rate_r       <= '0;
      wr_ptr_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_stamp_r <= last_stamp_nxt;
      sum_r        <= sum_nxt;
      count_r      <= count_nxt;
      mean_r       <= mean_nxt;
      frames_r     <= frames_nxt;
      acc_r        <= acc_nxt;
      rate_r       <= rate_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ticks_r    <= ticks_nxt;
    accept_r   <= accept_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `FIA_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `FIA_ASSERT_NOW(a_div_nonzero, clk, rst_n, div_start, count_r != '0)
  `FIA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE)
  `FIA_ASSERT_NOW(a_wait_divider, clk, rst_n, div_done, state_r == S_WAIT)

endmodule

@@ src/frame_interval_averager_top.sv @@
// Top level of the frame interval averager with its configuration register.
// Frame interval averager: each transaction carries a command and a 64-bit
// timestamp and yields one result with the frame interval, the window average,
// the frame rate and the sample count. On a tick the window average is formed
// by the bit-serial divider, one quotient bit per cycle, while a rebase skips
// the divider. The input stalls while a transaction is in progress, and a
// finished result waits in the output register while the next transaction is taken.
module frame_interval_averager_top import fia_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  logic [31:0] tps_r, tps_nxt;
  logic        cfg_write;
  logic        tps_sel;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign tps_sel    = cfg_paddr[CFG_ADDR_W-1:2] == REG_TPS;
  assign tps_nxt    = (cfg_write && tps_sel) ? cfg_pwdata : tps_r;
  assign cfg_prdata = tps_sel ? tps_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else begin
      tps_r <= tps_nxt;
    end
  end

  fia_ctrl #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .tps       (tps_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
